// ===== hdl/jndc_pkg.sv =====
`timescale 1ns / 1ps

package jndc_pkg;

  localparam int unsigned DEPTH_BITS_DEFAULT = 8;
  localparam logic [7:0]  DEPTH_LIMIT_RESET  = 8'd64;

  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_LBRACE    = 8'h7B;
  localparam logic [7:0] CH_RBRACE    = 8'h7D;
  localparam logic [7:0] CH_LBRACKET  = 8'h5B;
  localparam logic [7:0] CH_RBRACKET  = 8'h5D;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } text_beat_t;

endpackage

// ===== hdl/jndc_in_stage.sv =====
`timescale 1ns / 1ps

module jndc_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  jndc_pkg::text_beat_t beat_i,
  input  logic                drain_ok_i,
  output logic                stage_fire_o,
  output jndc_pkg::text_beat_t beat_o
);
  import jndc_pkg::*;

  logic       valid_q;
  text_beat_t beat_q;
  logic       advance;

  // non-final bytes make no result and always move on
  assign advance      = !beat_q.end_of_text || drain_ok_i;
  assign stage_fire_o = valid_q && advance;
  assign in_ready_o   = !valid_q || advance;
  assign beat_o       = beat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      beat_q <= beat_i;
    end
  end

endmodule

// ===== hdl/jndc_scan.sv =====
`timescale 1ns / 1ps

module jndc_scan #(
  parameter int unsigned DEPTH_BITS = jndc_pkg::DEPTH_BITS_DEFAULT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  jndc_pkg::text_beat_t beat_i,
  input  logic [7:0]           depth_limit_i,
  output logic                 within_limit_o
);
  import jndc_pkg::*;

  localparam int unsigned CW = ((DEPTH_BITS > 8) ? DEPTH_BITS : 8) + 1;

  logic [DEPTH_BITS-1:0] depth_q, depth_d;
  logic                  in_str_q, in_str_d;
  logic                  esc_q, esc_d;
  logic                  rej_q, rej_d;
  logic [CW-1:0]         depth_inc;
  logic [CW-1:0]         limit_ext;
  logic [7:0]            b;

  assign b         = beat_i.text_byte;
  assign depth_inc = CW'(depth_q) + CW'(1);
  assign limit_ext = CW'(depth_limit_i);

  always_comb begin
    depth_d  = depth_q;
    in_str_d = in_str_q;
    esc_d    = esc_q;
    rej_d    = rej_q;
    if (!rej_q) begin
      if (in_str_q) begin
        if (esc_q) begin
          esc_d = 1'b0;
        end else if (b == CH_BACKSLASH) begin
          esc_d = 1'b1;
        end else if (b == CH_QUOTE) begin
          in_str_d = 1'b0;
        end
      end else if (b == CH_QUOTE) begin
        in_str_d = 1'b1;
      end else if (b inside {CH_LBRACE, CH_LBRACKET}) begin
        // counter full rejects even under a larger limit
        if ((depth_q == '1) || (depth_inc > limit_ext)) begin
          rej_d = 1'b1;
        end else begin
          depth_d = depth_inc[DEPTH_BITS-1:0];
        end
      end else if (b inside {CH_RBRACE, CH_RBRACKET}) begin
        if (depth_q != '0) begin
          depth_d = depth_q - DEPTH_BITS'(1);
        end
      end
    end
  end

  assign within_limit_o = !rej_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q  <= '0;
      in_str_q <= 1'b0;
      esc_q    <= 1'b0;
      rej_q    <= 1'b0;
    end else if (fire_i) begin
      if (beat_i.end_of_text) begin
        depth_q  <= '0;
        in_str_q <= 1'b0;
        esc_q    <= 1'b0;
        rej_q    <= 1'b0;
      end else begin
        depth_q  <= depth_d;
        in_str_q <= in_str_d;
        esc_q    <= esc_d;
        rej_q    <= rej_d;
      end
    end
  end

endmodule

// ===== hdl/jndc_out_stage.sv =====
`timescale 1ns / 1ps

module jndc_out_stage (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  logic within_limit_i,
  output logic can_push_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output logic within_limit_o
);

  logic valid_q;
  logic data_q;

  assign can_push_o     = !valid_q || out_ready_i;
  assign out_valid_o    = valid_q;
  assign within_limit_o = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (can_push_o) begin
      valid_q <= push_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (can_push_o && push_i) begin
      data_q <= within_limit_i;
    end
  end

endmodule

// ===== hdl/json_nesting_depth_check.sv =====
`timescale 1ns / 1ps
// Channel  | Direction | Handshake              | Payload
// ---------+-----------+------------------------+------------------------------
// input    | in        | in_valid_i/in_ready_o  | text_byte_i, end_of_text_i
// result   | out       | out_valid_o/out_ready_i| within_limit_o
// config   | in        | cfg_we_i (no wait)     | cfg_wdata_i = depth_limit
//
// One byte per cycle sustained while the result is not stalled. A final byte
// goes into the input register, then through the scan logic straight into the
// result register, which then presents its result beat.
// Reset (async, active low) clears the scan state and both valid flags, and
// sets depth_limit to 64. A stalled result holds only final bytes back; other
// bytes keep flowing since they produce no result.

module json_nesting_depth_check #(
  parameter int unsigned DEPTH_BITS = jndc_pkg::DEPTH_BITS_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] text_byte_i,
  input  logic       end_of_text_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       within_limit_o,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i
);
  import jndc_pkg::*;

  text_beat_t in_beat;
  text_beat_t stage_beat;
  logic       stage_fire;
  logic       can_push;
  logic       scan_within;
  logic [7:0] depth_limit_q;

  assign in_beat.text_byte   = text_byte_i;
  assign in_beat.end_of_text = end_of_text_i;

  // limit register; the user must write it only while the block is idle (not enforced)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_limit_q <= DEPTH_LIMIT_RESET;
    end else if (cfg_we_i) begin
      depth_limit_q <= cfg_wdata_i;
    end
  end

  // input register: lets non-final bytes flow past result stalls
  jndc_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .beat_i       (in_beat),
    .drain_ok_i   (can_push),
    .stage_fire_o (stage_fire),
    .beat_o       (stage_beat)
  );

  // string/escape tracking, depth counter, reject flag
  jndc_scan #(
    .DEPTH_BITS (DEPTH_BITS)
  ) u_scan (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fire_i         (stage_fire),
    .beat_i         (stage_beat),
    .depth_limit_i  (depth_limit_q),
    .within_limit_o (scan_within)
  );

  // result register: loaded only by a final byte
  jndc_out_stage u_out (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (stage_fire && stage_beat.end_of_text),
    .within_limit_i (scan_within),
    .can_push_o     (can_push),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .within_limit_o (within_limit_o)
  );

endmodule

// ===== hdl/jndc_checker.sv =====
`timescale 1ns / 1ps

module jndc_sva (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic end_of_text_i,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic within_limit_o
);

  // a waiting result keeps its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(within_limit_o)))
    else $error("result changed while stalled");

  // with no result pending nothing can block the input
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty result register");

  // a non-final byte never blocks the next one
  a_nonfinal_flows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && !end_of_text_i) |=> in_ready_o)
    else $error("input stalled behind a non-final byte");

endmodule

bind json_nesting_depth_check jndc_sva u_jndc_sva (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .end_of_text_i  (end_of_text_i),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .within_limit_o (within_limit_o)
);
